### hw/rtl/lmp_pkg.sv
// Shared types and constants of the 3x3 local-maximum picker.
`timescale 1ns / 1ps
package lmp_pkg;

  localparam int OUTER_W   = 12;
  localparam int INNER_W   = 11;
  localparam int CORR_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;
  localparam int LL_FIELD_W = 12;
  localparam int LC_W      = 13;

  localparam int COUNT_MAX = 4096;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_CNT_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_THRESHOLD = 2'd2;

  localparam logic signed [CORR_W-1:0] THR_RESET = 32'sd10;
  localparam logic [LC_W-1:0]          LC_RESET  = 13'd1;

  // Neighbourhood check scheduled for one item.
  typedef struct packed {
    logic               active;
    logic               left_ok;
    logic               right_ok;
    logic               top_ok;
    logic               bottom_ok;
    logic [OUTER_W-1:0] outer;
    logic [INNER_W-1:0] inner;
  } chk_t;

  // One reported peak.
  typedef struct packed {
    logic [OUTER_W-1:0] outer;
    logic [INNER_W-1:0] inner;
    logic [CORR_W-1:0]  value;
  } res_t;

endpackage

### hw/rtl/lmp_if.sv
// Stream and configuration interfaces of the 3x3 local-maximum picker.
`timescale 1ns / 1ps
interface lmp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] corr_value;
  logic        is_pad;
  modport source (output valid, output corr_value, output is_pad, input ready);
  modport sink   (input valid, input corr_value, input is_pad, output ready);
endinterface

interface lmp_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] peak_outer;
  logic [10:0] peak_inner;
  logic [31:0] peak_value;
  modport source (output valid, output peak_outer, output peak_inner, output peak_value,
                  input ready);
  modport sink   (input valid, input peak_outer, input peak_inner, input peak_value,
                  output ready);
endinterface

interface lmp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/lmp_line_store.sv
// Two-line store: older and recent line packed per inner position, registered read.
`timescale 1ns / 1ps
module lmp_line_store #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A write landing on the same edge as the read is forwarded, so a one-pixel
  // line still sees the value written by the previous item.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/lmp_cell.sv
// One column of the 3x3 window: holds three rows and judges them against the centre.
`timescale 1ns / 1ps
module lmp_cell #(
  parameter int VB     = 32,
  parameter int COLUMN = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift_en,
  input  logic [2:0][VB-1:0]  col_in,
  output logic [2:0][VB-1:0]  col_out,
  input  logic [VB-1:0]       centre,
  input  logic                top_ok,
  input  logic                bottom_ok,
  output logic                beats
);

  logic [2:0][VB-1:0] col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift_en) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;

  // Rows run oldest (top) to newest (bottom). An equal value wins only from the
  // left column, or from the row above in the centre column.
  always_comb begin
    logic row_ok;
    logic gt;
    logic eq;
    logic eq_wins;
    beats = 1'b0;
    for (int r = 0; r < 3; r++) begin
      row_ok  = (r == 0) ? top_ok : ((r == 2) ? bottom_ok : 1'b1);
      gt      = $signed(col_r[r]) > $signed(centre);
      eq      = col_r[r] == centre;
      eq_wins = (COLUMN == 0) || ((COLUMN == 1) && (r == 0));
      if (row_ok && !((COLUMN == 1) && (r == 1)) && (gt || (eq && eq_wins))) begin
        beats = 1'b1;
      end
    end
  end

endmodule

### hw/rtl/lmp_out_fifo.sv
// Small result queue between the judging stage and the output channel.
`timescale 1ns / 1ps
module lmp_out_fifo
  import lmp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  res_t                 push_data,
  input  logic                 pop,
  output logic                 not_empty,
  output res_t                 head,
  output logic [OUT_CNT_W-1:0] count
);

  localparam int PtrW = $clog2(OUT_DEPTH);

  res_t                 entry_r [OUT_DEPTH];
  logic [PtrW-1:0]      wr_ptr_r;
  logic [PtrW-1:0]      rd_ptr_r;
  logic [OUT_CNT_W-1:0] count_r;
  logic                 do_pop;

  assign not_empty = count_r != '0;
  assign do_pop    = pop && not_empty;
  assign head      = entry_r[rd_ptr_r];
  assign count     = count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PtrW'(1);
      end
      if (push && !do_pop) begin
        count_r <= count_r + OUT_CNT_W'(1);
      end else if (!push && do_pop) begin
        count_r <= count_r - OUT_CNT_W'(1);
      end
    end
  end

endmodule

### hw/rtl/local_maximum_picker_3x3_top.sv
// Top level of the 3x3 local-maximum picker.
// Correlation values stream in scan order, one transfer per clock cycle sustained; the
// window is a chain of three column cells fed from a two-line store with one read and one
// write port, so every item uses each port once. A result passes from the transfer that
// decides it through stage one (line store read) and stage two (window cells) into a
// four-entry queue before it is offered on the output, and the input stalls only when
// that queue, counting results still in the two internal stages, could overflow.
// After a frame, line_length+1 pad transfers drain the window. Nothing needs clearing
// after reset: entries of the line store that were never written reach only masked rows.
`timescale 1ns / 1ps
module local_maximum_picker_3x3_top
  import lmp_pkg::*;
#(
  parameter int LINE_MAX   = 2048,
  parameter int VALUE_BITS = 32
) (
  input  logic   clk,
  input  logic   rst_n,
  lmp_in_if.sink    in_stream,
  lmp_out_if.source out_stream,
  lmp_cfg_if.sink   cfg_write
);

  localparam int XW   = $clog2(LINE_MAX);
  localparam int LW   = $clog2(LINE_MAX + 1);
  localparam int VB   = VALUE_BITS;
  localparam int CmpW = (VB > CORR_W) ? VB : CORR_W;

  // Geometry and threshold.
  logic [LW-1:0]            ll_r;
  logic [LC_W-1:0]          lc_r;
  logic signed [CORR_W-1:0] thr_r;

  // Stream position of the next item.
  logic [XW-1:0]   x_r;
  logic [LC_W-1:0] o_r;

  logic accept;
  logic in_ready;
  logic pixel;
  logic [VB-1:0] v_field;
  logic [VB-1:0] v_in;

  // Stage one: line store read data and the item's own value.
  logic          s1_valid_r;
  logic [VB-1:0] s1_v_r;
  logic [XW-1:0] s1_xs_r;
  chk_t          s1_chk_r;
  chk_t          chk_nxt;

  // Stage two: window holds the item's shifted state.
  logic s2_valid_r;
  chk_t s2_chk_r;

  logic [2*VB-1:0]     rd_data;
  logic [2:0][VB-1:0]  col_new;
  logic [2:0][VB-1:0]  col_l;
  logic [2:0][VB-1:0]  col_c;
  logic [2:0][VB-1:0]  col_r;
  logic                beats_l;
  logic                beats_c;
  logic                beats_r;
  logic [VB-1:0]       centre;
  logic                peak;
  res_t                res;

  logic [OUT_CNT_W-1:0] fifo_count;
  logic [OUT_CNT_W-1:0] pending;
  logic                 fifo_not_empty;
  res_t                 fifo_head;

  // ---------------------------------------------------------------- config
  logic                  cfg_fire;
  logic                  geo_write;
  logic [13:0]           ll_raw;
  logic [13:0]           ll_clamp;
  logic [LC_W-1:0]       lc_raw;
  logic [LC_W-1:0]       lc_clamp;

  assign cfg_write.ready = 1'b1;
  assign cfg_fire        = cfg_write.valid;
  assign geo_write       = cfg_fire &&
                           (cfg_write.index inside {REG_LINE_LENGTH, REG_LINE_COUNT});

  always_comb begin
    ll_raw   = 14'(cfg_write.data[LL_FIELD_W-1:0]);
    ll_clamp = (ll_raw == '0) ? 14'd1 : ((ll_raw > 14'(LINE_MAX)) ? 14'(LINE_MAX) : ll_raw);
    lc_raw   = cfg_write.data[LC_W-1:0];
    lc_clamp = (lc_raw == '0) ? 13'd1 : ((lc_raw > 13'(COUNT_MAX)) ? 13'(COUNT_MAX) : lc_raw);
  end

  // ---------------------------------------------------------------- input value
  generate
    if (VB <= CORR_W) begin : g_narrow
      assign v_field = in_stream.corr_value[VB-1:0];
    end else begin : g_wide
      assign v_field = {{(VB - CORR_W){1'b0}}, in_stream.corr_value};
    end
  endgenerate

  assign pixel = (o_r < lc_r) && !in_stream.is_pad;
  assign v_in  = pixel ? v_field : '0;

  // ---------------------------------------------------------------- position
  logic [LC_W-1:0] o_m1;
  logic [LC_W-1:0] o_m2;
  logic            chk_a;
  logic            chk_b;
  logic [XW:0]     x_inc;
  logic            wrap;
  logic [XW-1:0]   x_n;
  logic [LC_W-1:0] o_n;
  logic [LC_W:0]   lc_p1;
  logic            frame_done;

  always_comb begin
    o_m1 = o_r - 13'd1;
    o_m2 = o_r - 13'd2;
    // At a line start the last pixel of the line two back is decided; otherwise
    // the pixel one line up and one position left.
    chk_a = (x_r == '0) && (o_r >= 13'd2) && (o_m2 < lc_r);
    chk_b = (x_r != '0) && (o_r >= 13'd1) && (o_m1 < lc_r);

    chk_nxt.active    = chk_a || chk_b;
    chk_nxt.left_ok   = chk_a ? (ll_r >= LW'(2)) : (XW'(x_r) >= XW'(2));
    chk_nxt.right_ok  = chk_b;
    chk_nxt.top_ok    = chk_a ? (o_r >= 13'd3) : (o_r >= 13'd2);
    chk_nxt.bottom_ok = chk_a ? (o_m1 < lc_r) : (o_r < lc_r);
    chk_nxt.outer     = chk_a ? OUTER_W'(o_m2) : OUTER_W'(o_m1);
    chk_nxt.inner     = chk_a ? INNER_W'(ll_r - LW'(1)) : INNER_W'(x_r - XW'(1));

    x_inc = {1'b0, x_r} + (XW + 1)'(1);
    wrap  = x_inc >= (XW + 1)'(ll_r);
    x_n   = wrap ? '0 : x_inc[XW-1:0];
    o_n   = wrap ? (o_r + 13'd1) : o_r;
    lc_p1 = {1'b0, lc_r} + 14'd1;
    frame_done = ({1'b0, o_n} > lc_p1) || (({1'b0, o_n} == lc_p1) && (x_n != '0));
  end

  // ---------------------------------------------------------------- handshake
  assign pending  = fifo_count + OUT_CNT_W'(s1_valid_r) + OUT_CNT_W'(s2_valid_r);
  assign in_ready = pending < OUT_CNT_W'(OUT_DEPTH);
  assign in_stream.ready = in_ready;
  assign accept   = in_stream.valid && in_ready;

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ll_r       <= LW'(1);
      lc_r       <= LC_RESET;
      thr_r      <= THR_RESET;
      x_r        <= '0;
      o_r        <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      s2_valid_r <= s1_valid_r;
      // A geometry write restarts the frame and takes precedence over a transfer.
      if (geo_write) begin
        x_r <= '0;
        o_r <= '0;
      end else if (accept) begin
        x_r <= frame_done ? '0 : x_n;
        o_r <= frame_done ? '0 : o_n;
      end
      if (cfg_fire) begin
        unique case (cfg_write.index)
          REG_LINE_LENGTH: begin
            ll_r <= LW'(ll_clamp);
          end
          REG_LINE_COUNT: begin
            lc_r <= lc_clamp;
          end
          REG_PEAK_THRESHOLD: begin
            thr_r <= cfg_write.data;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- payload regs
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_v_r   <= v_in;
      s1_xs_r  <= x_r;
      s1_chk_r <= chk_nxt;
    end
    s2_chk_r <= s1_chk_r;
  end

  // ---------------------------------------------------------------- line store
  lmp_line_store #(
    .DEPTH (LINE_MAX),
    .WIDTH (2 * VB)
  ) u_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (x_r),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_xs_r),
    .wr_data ({rd_data[VB-1:0], s1_v_r}),
    .rd_data (rd_data)
  );

  // ---------------------------------------------------------------- window chain
  assign col_new[0] = rd_data[2*VB-1:VB];
  assign col_new[1] = rd_data[VB-1:0];
  assign col_new[2] = s1_v_r;
  assign centre     = col_c[1];

  lmp_cell #(.VB(VB), .COLUMN(2)) u_cell_r (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift_en  (s1_valid_r),
    .col_in    (col_new),
    .col_out   (col_r),
    .centre    (centre),
    .top_ok    (s2_chk_r.top_ok),
    .bottom_ok (s2_chk_r.bottom_ok),
    .beats     (beats_r)
  );

  lmp_cell #(.VB(VB), .COLUMN(1)) u_cell_c (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift_en  (s1_valid_r),
    .col_in    (col_r),
    .col_out   (col_c),
    .centre    (centre),
    .top_ok    (s2_chk_r.top_ok),
    .bottom_ok (s2_chk_r.bottom_ok),
    .beats     (beats_c)
  );

  // The left column is read only through the cell's own judgement.
  lmp_cell #(.VB(VB), .COLUMN(0)) u_cell_l (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift_en  (s1_valid_r),
    .col_in    (col_c),
    .col_out   (col_l),
    .centre    (centre),
    .top_ok    (s2_chk_r.top_ok),
    .bottom_ok (s2_chk_r.bottom_ok),
    .beats     (beats_l)
  );

  // ---------------------------------------------------------------- judgement
  always_comb begin
    peak = s2_valid_r && s2_chk_r.active
        && !((beats_l && s2_chk_r.left_ok) || beats_c || (beats_r && s2_chk_r.right_ok))
        && (CmpW'($signed(centre)) > CmpW'(thr_r));
    res.outer = s2_chk_r.outer;
    res.inner = s2_chk_r.inner;
    res.value = CORR_W'($signed(centre));
  end

  lmp_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (peak),
    .push_data (res),
    .pop       (out_stream.ready),
    .not_empty (fifo_not_empty),
    .head      (fifo_head),
    .count     (fifo_count)
  );

  assign out_stream.valid      = fifo_not_empty;
  assign out_stream.peak_outer = fifo_head.outer;
  assign out_stream.peak_inner = fifo_head.inner;
  assign out_stream.peak_value = fifo_head.value;

endmodule
